### design/i8bsd_pkg.sv
// Shared types and constants for the int8 block-scaled dot product unit.
// No dependencies.
`default_nettype none
package i8bsd_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [31:0] F32_QNAN    = 32'h7fc0_0000;
	localparam logic [7:0]  F32_EXP_MAX = 8'hff;

	// One finished block and/or dot end, handed from front to back.
	typedef struct packed {
		logic [31:0] sum;
		logic [15:0] lhs_scale;
		logic [15:0] rhs_scale;
		logic        do_block;
		logic        do_dot;
	} cmd_t;

	// Widened binary16: value = m * 2^e when finite and nonzero.
	typedef struct packed {
		logic              nan;
		logic              inf;
		logic              zero;
		logic              s;
		logic [10:0]       m;
		logic signed [6:0] e;
	} half_t;

	function automatic half_t half_unpack(input logic [15:0] h);
		half_t r;
		r.s    = h[15];
		r.nan  = (h[14:10] == 5'h1f) && (h[9:0] != 10'd0);
		r.inf  = (h[14:10] == 5'h1f) && (h[9:0] == 10'd0);
		r.zero = (h[14:0] == 15'd0);
		if (h[14:10] == 5'd0) begin
			r.m = {1'b0, h[9:0]};
			r.e = -7'sd24;
		end else begin
			r.m = {1'b1, h[9:0]};
			r.e = 7'(signed'({2'b00, h[14:10]}) - 7'sd25);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### design/i8bsd_front.sv
// Front end: accepts element pairs, keeps the exact block sum, and queues
// a command per block end or dot end. Depends on i8bsd_pkg.
`default_nettype none
module i8bsd_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  signed [7:0]    lhs_value,
	input  wire  signed [7:0]    rhs_value,
	input  wire         [15:0]   lhs_scale,
	input  wire         [15:0]   rhs_scale,
	input  wire                  pair_valid,
	input  wire                  last_in_block,
	input  wire                  last_in_dot,
	input  wire                  q_full,
	output logic                 q_push,
	output i8bsd_pkg::cmd_t      q_data
);
	import i8bsd_pkg::*;

	logic [31:0]        sum_q;
	logic signed [15:0] prod;
	logic [31:0]        sum_next;
	logic               fire;
	logic               close_block;

	assign in_ready    = !q_full;
	assign fire        = in_valid && in_ready;
	assign prod        = lhs_value * rhs_value;
	assign sum_next    = pair_valid ? sum_q + 32'(prod) : sum_q;
	assign close_block = pair_valid && last_in_block;
	assign q_push      = fire && (close_block || last_in_dot);

	always_comb begin
		q_data.sum       = sum_next;
		q_data.lhs_scale = lhs_scale;
		q_data.rhs_scale = rhs_scale;
		q_data.do_block  = close_block;
		q_data.do_dot    = last_in_dot;
	end

	// an open block is dropped when the dot closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (fire) begin
			sum_q <= (close_block || last_in_dot) ? 32'd0 : sum_next;
		end
	end

endmodule
`default_nettype wire

### design/i8bsd_queue.sv
// Short command queue between front and back ends.
// Depends on i8bsd_pkg.
`default_nettype none
module i8bsd_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  i8bsd_pkg::cmd_t  push_data,
	output logic             full,
	input  wire              pop,
	output logic             avail,
	output i8bsd_pkg::cmd_t  pop_data
);
	import i8bsd_pkg::*;

	cmd_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QPTR_W:0]    cnt_q;

	assign full     = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign avail    = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule
`default_nettype wire

### design/i8bsd_back.sv
// Back end: scale widening, sum conversion, scaled multiply and float32
// accumulate with round-to-nearest-even; drives the result register. Uses i8bsd_pkg.
`default_nettype none
module i8bsd_back (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              q_avail,
	input  i8bsd_pkg::cmd_t  q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [31:0]      out_data
);
	import i8bsd_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_WIDEN = 6'b000010,
		ST_NORM  = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_ADD   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		PH_ISUM = 3'b001,
		PH_PROD = 3'b010,
		PH_ACC  = 3'b100
	} phase_t;

	state_t             state_q;
	state_t             done_st;
	phase_t             phase_q;
	cmd_t               cmd_q;
	logic [31:0]        acc_q;
	logic [31:0]        rbits_q;
	logic [47:0]        nm_q;
	logic signed [11:0] ne_q;
	logic               ns_q;
	logic               sc_nan_q, sc_inf_q, sc_zero_q, sc_s_q;
	logic [21:0]        sc_m_q;
	logic signed [7:0]  sc_e_q;
	logic               out_valid_q;
	logic [31:0]        out_data_q;

	// widen
	half_t              hl, hr;
	logic               w_nan, w_inf;
	logic [31:0]        sum_mag;

	// round of normalized value nm_q * 2^ne_q
	logic               r_up;
	logic [24:0]        r_sum;
	logic signed [11:0] r_be;
	logic [31:0]        r_bits;

	// multiply
	logic               i_zero;
	logic [23:0]        i_m;
	logic [45:0]        m_prod;
	logic signed [11:0] m_e;

	// add
	logic               a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
	logic               swap;
	logic [31:0]        x_f, y_f;
	logic [7:0]         d_exp;
	logic [47:0]        x_m, y_m0, y_m, y_lost;
	logic [47:0]        add_m;
	logic               emit_ok;

	assign hl     = half_unpack(cmd_q.lhs_scale);
	assign hr     = half_unpack(cmd_q.rhs_scale);
	assign w_nan  = hl.nan || hr.nan || (hl.inf && hr.zero) || (hr.inf && hl.zero);
	assign w_inf  = (hl.inf || hr.inf) && !w_nan;
	assign sum_mag = cmd_q.sum[31] ? (~cmd_q.sum + 32'd1) : cmd_q.sum;

	assign r_up  = nm_q[23] && ((|nm_q[22:0]) || nm_q[24]);
	assign r_sum = {1'b0, nm_q[47:24]} + 25'(r_up);
	assign r_be  = ne_q + 12'sd174 + 12'(r_sum[24]);
	always_comb begin
		if (r_be >= 12'sd255) begin
			r_bits = {ns_q, F32_EXP_MAX, 23'd0};
		end else begin
			r_bits = {ns_q, r_be[7:0], r_sum[24] ? 23'd0 : r_sum[22:0]};
		end
	end

	assign i_zero = (rbits_q[30:0] == 31'd0);
	assign i_m    = {1'b1, rbits_q[22:0]};
	assign m_prod = sc_m_q * i_m;
	assign m_e    = 12'(sc_e_q) + signed'({4'b0, rbits_q[30:23]}) - 12'sd150;

	assign a_nan  = (acc_q[30:23] == F32_EXP_MAX) && (acc_q[22:0] != 23'd0);
	assign a_inf  = (acc_q[30:0] == {F32_EXP_MAX, 23'd0});
	assign a_zero = (acc_q[30:0] == 31'd0);
	assign b_nan  = (rbits_q[30:23] == F32_EXP_MAX) && (rbits_q[22:0] != 23'd0);
	assign b_inf  = (rbits_q[30:0] == {F32_EXP_MAX, 23'd0});
	assign b_zero = (rbits_q[30:0] == 31'd0);
	assign swap   = rbits_q[30:0] > acc_q[30:0];
	assign x_f    = swap ? rbits_q : acc_q;
	assign y_f    = swap ? acc_q : rbits_q;
	assign d_exp  = x_f[30:23] - y_f[30:23];
	assign x_m    = {1'b0, 1'b1, x_f[22:0], 23'd0};
	assign y_m0   = {1'b0, 1'b1, y_f[22:0], 23'd0};
	assign y_lost = y_m0 & ~({48{1'b1}} << d_exp[5:0]);
	assign y_m    = (d_exp >= 8'd48) ? 48'd1 : ((y_m0 >> d_exp[5:0]) | 48'(|y_lost));
	assign add_m  = (x_f[31] == y_f[31]) ? x_m + y_m : x_m - y_m;

	assign done_st  = cmd_q.do_dot ? ST_EMIT : ST_IDLE;
	assign emit_ok  = !out_valid_q || out_ready;
	assign q_pop    = (state_q == ST_IDLE) && q_avail;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_ISUM;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			rbits_q     <= '0;
			nm_q        <= '0;
			ne_q        <= '0;
			ns_q        <= 1'b0;
			sc_nan_q    <= 1'b0;
			sc_inf_q    <= 1'b0;
			sc_zero_q   <= 1'b0;
			sc_s_q      <= 1'b0;
			sc_m_q      <= '0;
			sc_e_q      <= '0;
		end else begin
			// ST_EMIT reloads the result register itself
			if (out_valid_q && out_ready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_avail) begin
						state_q <= q_data.do_block ? ST_WIDEN : ST_EMIT;
					end
				end
				ST_WIDEN: begin
					sc_nan_q  <= w_nan;
					sc_inf_q  <= w_inf;
					sc_zero_q <= (hl.zero || hr.zero) && !w_nan && !w_inf;
					sc_s_q    <= hl.s ^ hr.s;
					sc_m_q    <= hl.m * hr.m;
					sc_e_q    <= 8'(hl.e) + 8'(hr.e);
					if (cmd_q.sum == 32'd0) begin
						rbits_q <= '0;
						state_q <= ST_MUL;
					end else begin
						nm_q    <= {sum_mag, 16'd0};
						ne_q    <= -12'sd16;
						ns_q    <= cmd_q.sum[31];
						phase_q <= PH_ISUM;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (nm_q[47]) begin
						case (phase_q)
							PH_ISUM: begin
								rbits_q <= r_bits;
								state_q <= ST_MUL;
							end
							PH_PROD: begin
								rbits_q <= r_bits;
								state_q <= ST_ADD;
							end
							default: begin
								acc_q   <= r_bits;
								state_q <= done_st;
							end
						endcase
					end else if (nm_q[47:40] == 8'd0) begin
						nm_q <= nm_q << 8;
						ne_q <= ne_q - 12'sd8;
					end else begin
						nm_q <= nm_q << 1;
						ne_q <= ne_q - 12'sd1;
					end
				end
				ST_MUL: begin
					if (sc_nan_q || (sc_inf_q && i_zero)) begin
						rbits_q <= F32_QNAN;
						state_q <= ST_ADD;
					end else if (sc_inf_q) begin
						rbits_q <= {sc_s_q ^ rbits_q[31], F32_EXP_MAX, 23'd0};
						state_q <= ST_ADD;
					end else if (sc_zero_q || i_zero) begin
						rbits_q <= {sc_s_q ^ rbits_q[31], 31'd0};
						state_q <= ST_ADD;
					end else begin
						nm_q    <= {2'b00, m_prod};
						ne_q    <= m_e;
						ns_q    <= sc_s_q ^ rbits_q[31];
						phase_q <= PH_PROD;
						state_q <= ST_NORM;
					end
				end
				ST_ADD: begin
					if (a_nan || b_nan || (a_inf && b_inf && (acc_q[31] != rbits_q[31]))) begin
						acc_q   <= F32_QNAN;
						state_q <= done_st;
					end else if (a_inf) begin
						state_q <= done_st;
					end else if (b_inf) begin
						acc_q   <= rbits_q;
						state_q <= done_st;
					end else if (b_zero) begin
						acc_q   <= a_zero ? {acc_q[31] & rbits_q[31], 31'd0} : acc_q;
						state_q <= done_st;
					end else if (a_zero) begin
						acc_q   <= rbits_q;
						state_q <= done_st;
					end else if (add_m == 48'd0) begin
						acc_q   <= '0;
						state_q <= done_st;
					end else begin
						nm_q    <= add_m;
						ne_q    <= signed'({4'b0, x_f[30:23]}) - 12'sd173;
						ns_q    <= x_f[31];
						phase_q <= PH_ACC;
						state_q <= ST_NORM;
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						out_valid_q <= 1'b1;
						out_data_q  <= (acc_q[30:0] > {F32_EXP_MAX, 23'd0}) ? F32_QNAN : acc_q;
						acc_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### design/int8_block_scaled_dot_product_unit.sv
// Int8 block-scaled dot product, top level. Depends on i8bsd_pkg, i8bsd_front,
// i8bsd_queue and i8bsd_back.
// Throughput: one word per cycle into the front end while the queue is not full;
// the back end takes a closed block through up to three normalize/round loops and the
// accumulate on its shared normalize unit; a 4-entry command queue absorbs the
// difference. A dot-end word passes the queue and the back end's idle state to its
// emit state, after the block processing when it also closes a block. Reset clears
// the block sum, accumulator (+0.0) and queue.
`default_nettype none
module int8_block_scaled_dot_product_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] lhs_value, [15:8] rhs_value, [31:16] lhs_scale, [47:32] rhs_scale
	input  wire  [47:0] s_axis_tdata,
	// [0] pair_valid, [1] last_in_block
	input  wire  [1:0]  s_axis_tuser,
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [31:0] dot_result
	output logic [31:0] m_axis_tdata
);
	import i8bsd_pkg::*;

	cmd_t push_data, pop_data;
	logic push, pop, full, avail;

	i8bsd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.lhs_value     (s_axis_tdata[7:0]),
		.rhs_value     (s_axis_tdata[15:8]),
		.lhs_scale     (s_axis_tdata[31:16]),
		.rhs_scale     (s_axis_tdata[47:32]),
		.pair_valid    (s_axis_tuser[0]),
		.last_in_block (s_axis_tuser[1]),
		.last_in_dot   (s_axis_tlast),
		.q_full        (full),
		.q_push        (push),
		.q_data        (push_data)
	);

	i8bsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.avail     (avail),
		.pop_data  (pop_data)
	);

	i8bsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_avail   (avail),
		.q_data    (pop_data),
		.q_pop     (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
`default_nettype wire

### tb/tb_int8_block_scaled_dot_product_unit.sv
// Self-checking testbench for int8_block_scaled_dot_product_unit.
// Runs directed and random word streams against a bit-exact float32 model of the
// unit, with random stalls on both sides. Depends on i8bsd_pkg and the RTL.
`timescale 1ns / 1ps
module tb_int8_block_scaled_dot_product_unit;
	import i8bsd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_WORDS = 1950;

	typedef struct {
		bit          nan;
		bit          inf;
		bit          zero;
		bit          s;
		longint unsigned m;
		int          e;
	} fnum_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	// model state
	logic [31:0] blk_sum = '0;
	logic [31:0] dot_acc = '0;
	logic [31:0] expected_dots[$];

	int  errors = 0;
	int  words_sent = 0;
	int  dots_seen = 0;
	int  cycles = 0;
	bit  steady = 1'b0;
	int  hold_req = 0;
	int  hold_seen = 0;
	int  hold_left = 0;

	int8_block_scaled_dot_product_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic fnum_t unpack_f32(logic [31:0] b);
		fnum_t r;
		r.s = b[31];
		r.nan = (b[30:23] == 8'hff) && (b[22:0] != 0);
		r.inf = (b[30:23] == 8'hff) && (b[22:0] == 0);
		r.zero = (b[30:0] == 0);
		if (b[30:23] == 0) begin
			r.m = b[22:0];
			r.e = -149;
		end else begin
			r.m = {1'b1, b[22:0]};
			r.e = int'(b[30:23]) - 150;
		end
		return r;
	endfunction

	function automatic fnum_t unpack_f16(logic [15:0] h);
		fnum_t r;
		r.s = h[15];
		r.nan = (h[14:10] == 5'h1f) && (h[9:0] != 0);
		r.inf = (h[14:10] == 5'h1f) && (h[9:0] == 0);
		r.zero = (h[14:0] == 0);
		if (h[14:10] == 0) begin
			r.m = h[9:0];
			r.e = -24;
		end else begin
			r.m = {1'b1, h[9:0]};
			r.e = int'(h[14:10]) - 25;
		end
		return r;
	endfunction

	// Round sign * mag * 2^e to float32, nearest-even, with subnormals and overflow.
	function automatic logic [31:0] round_f32(bit s, longint unsigned mag, int e);
		int p, lsb, drop, be;
		longint unsigned m, rem, half, one;
		bit up;
		one = 1;
		if (mag == 0)
			return {s, 31'd0};
		p = 63;
		while (!mag[p])
			p--;
		lsb = p + e - 23;
		if (lsb < -149)
			lsb = -149;
		drop = lsb - e;
		up = 1'b0;
		if (drop <= 0) begin
			m = mag << (-drop);
		end else if (drop >= 64) begin
			m = 0;
			up = (drop == 64) && (mag > 64'h8000_0000_0000_0000);
		end else begin
			m = mag >> drop;
			rem = mag & ((one << drop) - 1);
			half = one << (drop - 1);
			up = (rem > half) || (rem == half && m[0]);
		end
		m = m + up;
		if (m[24]) begin
			m = m >> 1;
			lsb++;
		end
		if (m[23]) begin
			be = lsb + 150;
			if (be >= 255)
				return {s, 8'hff, 23'd0};
			return {s, 8'(be), m[22:0]};
		end
		return {s, 8'd0, m[22:0]};
	endfunction

	function automatic logic [31:0] add_f32(logic [31:0] a, logic [31:0] b);
		fnum_t x, y, t;
		longint unsigned mx, my, rest, one, mag;
		int d;
		bit s;
		one = 1;
		x = unpack_f32(a);
		y = unpack_f32(b);
		if (x.nan || y.nan)
			return F32_QNAN;
		if (x.inf && y.inf)
			return (x.s != y.s) ? F32_QNAN : a;
		if (x.inf)
			return a;
		if (y.inf)
			return b;
		if (x.zero && y.zero)
			return {x.s & y.s, 31'd0};
		if (x.zero)
			return b;
		if (y.zero)
			return a;
		if (x.e < y.e) begin
			t = x;
			x = y;
			y = t;
		end
		// 39 guard bits keep the sum inside 64 bits; lost bits fold into a sticky
		mx = x.m << 39;
		my = y.m << 39;
		d = x.e - y.e;
		if (d >= 64) begin
			my = (my != 0);
		end else if (d > 0) begin
			rest = my & ((one << d) - 1);
			my = (my >> d) | (rest != 0);
		end
		if (x.s == y.s) begin
			mag = mx + my;
			s = x.s;
		end else if (mx == my) begin
			return 32'd0;
		end else if (mx > my) begin
			mag = mx - my;
			s = x.s;
		end else begin
			mag = my - mx;
			s = y.s;
		end
		return round_f32(s, mag, x.e - 39);
	endfunction

	// (lhs_scale * rhs_scale) * isum; the scale product is exact so one rounding.
	function automatic logic [31:0] block_term(logic [15:0] ls, logic [15:0] rs,
			logic [31:0] isum);
		fnum_t h1, h2, f;
		bit s;
		h1 = unpack_f16(ls);
		h2 = unpack_f16(rs);
		f = unpack_f32(isum);
		s = h1.s ^ h2.s ^ f.s;
		if (h1.nan || h2.nan)
			return F32_QNAN;
		if (h1.inf || h2.inf) begin
			if (h1.zero || h2.zero || f.zero)
				return F32_QNAN;
			return {s, 8'hff, 23'd0};
		end
		if (h1.zero || h2.zero || f.zero)
			return {s, 31'd0};
		return round_f32(s, h1.m * h2.m * f.m, h1.e + h2.e + f.e);
	endfunction

	task automatic model_word(logic signed [7:0] lhs, logic signed [7:0] rhs,
			logic [15:0] ls, logic [15:0] rs, bit pv, bit lb, bit ld);
		logic [31:0] mag, isum, r;
		if (pv) begin
			blk_sum = blk_sum + 32'(int'(lhs) * int'(rhs));
			if (lb) begin
				mag = blk_sum[31] ? -blk_sum : blk_sum;
				isum = round_f32(blk_sum[31], {32'd0, mag}, 0);
				dot_acc = add_f32(dot_acc, block_term(ls, rs, isum));
				blk_sum = '0;
			end
		end
		if (ld) begin
			r = dot_acc;
			if ((r & 32'h7fff_ffff) > 32'h7f80_0000)
				r = F32_QNAN;
			expected_dots.push_back(r);
			dot_acc = '0;
			blk_sum = '0;
		end
	endtask

	task automatic send_word(logic [7:0] lhs, logic [7:0] rhs, logic [15:0] ls,
			logic [15:0] rs, bit pv, bit lb, bit ld);
		while (!steady && $urandom_range(99) < 11) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {rs, ls, rhs, lhs};
		s_axis_tuser <= {lb, pv};
		s_axis_tlast <= ld;
		do
			@(posedge clk);
		while (!s_axis_tready);
		model_word(lhs, rhs, ls, rs, pv, lb, ld);
		words_sent++;
	endtask

	function automatic logic [15:0] rand_scale();
		int k;
		k = $urandom_range(99);
		if (k < 70)
			return {1'($urandom), 5'($urandom_range(22, 8)), 10'($urandom)};
		if (k < 90)
			return {1'($urandom), 5'($urandom_range(30, 0)), 10'($urandom)};
		return 16'($urandom);
	endfunction

	function automatic logic [7:0] rand_elem();
		int k;
		k = $urandom_range(99);
		if (k < 10)
			return 8'h80;
		if (k < 20)
			return 8'h7f;
		if (k < 25)
			return 8'hff;
		return 8'($urandom);
	endfunction

	task automatic test_extremes();
		send_word(8'h80, 8'h80, 16'h3c00, 16'h3c00, 1, 1, 1);
		send_word(8'h7f, 8'h80, 16'h7bff, 16'h7bff, 1, 1, 1);
		send_word(8'h01, 8'h01, 16'h0001, 16'h0001, 1, 1, 1);
		send_word(8'h7f, 8'h7f, 16'hfbff, 16'h03ff, 1, 0, 0);
		send_word(8'h80, 8'h7f, 16'h3555, 16'hc001, 1, 1, 1);
	endtask

	task automatic test_scale_specials();
		send_word(8'h01, 8'h01, 16'h03ff, 16'h8000, 1, 1, 1);   // negative zero scale
		send_word(8'h02, 8'h03, 16'h7c00, 16'h3c00, 1, 1, 1);   // infinite scale
		send_word(8'h00, 8'h05, 16'h7c00, 16'h3c00, 1, 1, 1);   // inf times zero sum
		send_word(8'h01, 8'h01, 16'h0000, 16'hfc00, 1, 1, 1);   // zero times inf
		send_word(8'h01, 8'h01, 16'h7e00, 16'h3c00, 1, 1, 1);   // NaN scale
		send_word(8'h01, 8'h01, 16'hfc00, 16'h3c00, 1, 1, 0);
		send_word(8'h01, 8'h01, 16'h7c00, 16'h3c00, 1, 1, 1);   // inf minus inf
		send_word(8'h01, 8'h01, 16'h7fff, 16'hffff, 1, 1, 1);
	endtask

	task automatic test_dot_framing();
		send_word(8'h11, 8'h22, 16'h3c00, 16'h3c00, 0, 0, 1);   // empty dot
		send_word(8'h7f, 8'h7f, 16'h3c00, 16'h3c00, 0, 1, 0);   // no pair: ignored
		send_word(8'h05, 8'h05, 16'h3c00, 16'h3c00, 1, 0, 0);
		send_word(8'h05, 8'h05, 16'h3c00, 16'h3c00, 1, 0, 1);   // open block dropped
		send_word(8'h01, 8'h01, 16'h3c00, 16'h3c00, 1, 1, 1);
		send_word(8'h03, 8'hfd, 16'h4000, 16'h3800, 1, 1, 0);
		send_word(8'h80, 8'h80, 16'h3c00, 16'h3c00, 0, 0, 1);   // close via no-pair word
	endtask

	// Receiver blocks for a long stretch while single-word dots keep coming.
	task automatic test_backpressure();
		hold_req++;
		repeat (40)
			send_word(rand_elem(), rand_elem(), rand_scale(), rand_scale(), 1, 1, 1);
	endtask

	task automatic test_random();
		int sent, nblk, len, k;
		bit brk;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			steady = (sent > 600 && sent < 900);
			k = $urandom_range(99);
			if (k < 5) begin
				send_word(rand_elem(), rand_elem(), rand_scale(), rand_scale(), 0, 0, 1);
				sent++;
				continue;
			end
			if (k < 12) begin
				send_word(rand_elem(), rand_elem(), rand_scale(), rand_scale(), 0,
					1'($urandom), 0);
				sent++;
			end
			nblk = $urandom_range(4, 1);
			brk = ($urandom_range(99) < 6);
			for (int b = 0; b < nblk; b++) begin
				len = ($urandom_range(99) < 3) ? $urandom_range(256, 33) :
					$urandom_range(32, 1);
				for (int i = 0; i < len; i++) begin
					bit endb, endd;
					endb = (i == len - 1);
					endd = endb && (b == nblk - 1);
					send_word(rand_elem(), rand_elem(), rand_scale(), rand_scale(), 1,
						endb && !(brk && endd), endd);
					sent++;
				end
			end
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || ($urandom_range(99) >= 11);
		end
	end

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			dots_seen++;
			if (expected_dots.size() == 0) begin
				$error("unexpected dot_result word %h", m_axis_tdata);
				errors++;
			end else begin
				want = expected_dots.pop_front();
				if (m_axis_tdata !== want) begin
					$error("dot_result mismatch: expected %h, actual %h", want, m_axis_tdata);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_scale_specials();
		test_dot_framing();
		test_backpressure();
		test_random();
		s_axis_tvalid <= 1'b0;
		while (expected_dots.size() != 0)
			@(posedge clk);
		repeat (60)
			@(posedge clk);
		$display("sent %0d words, checked %0d dot results", words_sent, dots_seen);
		$display("covered scale specials, empty and broken dots, long blocks, backpressure");
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
